@@ design/rbd_pkg.sv @@
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared widths and constants for the run-length byte decoder.
// ----------------------------------------------------------------------------
package rbd_pkg;

    localparam int CNT_BITS_DEF = 24;
    localparam int BYTE_W       = 8;
    localparam int SIZE_W       = 24;
    localparam int REP_W        = 7;

    localparam int          LIT_FLAG_BIT = 7;
    localparam logic [6:0]  LEN_MASK     = 7'h7F;

endpackage

@@ design/rle_byte_decoder.sv @@
// ----------------------------------------------------------------------------
// rle_byte_decoder
// Run-length decoder: one compressed byte in, one value/repeat beat out.
// ----------------------------------------------------------------------------
// The block takes one compressed byte per clock and returns one result beat
// per byte, registered and held in its output register; the input side stalls
// only while that register holds a beat that has not been taken. Runs leave
// as a value plus a repeat count (0..127) and are never expanded. The output
// limit is sampled from i_out_size on the first byte of each frame and the
// count of bytes produced is clipped to it; once reached, the rest of the
// frame gives empty beats with o_output_full set. i_in_last ends the frame
// and the next byte starts a fresh one. COUNT_BITS sets the width of the
// internal byte counters; a larger limit saturates to their maximum.
module rle_byte_decoder
    import rbd_pkg::*;
#(
    parameter int COUNT_BITS = CNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic [SIZE_W-1:0] i_out_size,
    input  logic              i_in_last,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [BYTE_W-1:0] o_out_value,
    output logic [REP_W-1:0]  o_repeat_res,
    output logic              o_frame_end,
    output logic              o_output_full
);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LITERAL = 2'd1,
        PH_RUNVAL  = 2'd2
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [REP_W-1:0]      r_pending, n_pending;
    logic [COUNT_BITS-1:0] r_produced, n_produced;
    logic [COUNT_BITS-1:0] r_limit, n_limit;
    logic                  r_frame_start, n_frame_start;

    logic                  r_out_valid;
    logic [BYTE_W-1:0]     r_out_value, n_out_value;
    logic [REP_W-1:0]      r_repeat_res, n_repeat_res;
    logic                  r_frame_end;
    logic                  r_output_full, n_output_full;

    logic                  accept;
    logic [COUNT_BITS-1:0] size_sat;
    t_phase                cur_phase;
    logic [REP_W-1:0]      cur_pending;
    logic [COUNT_BITS-1:0] cur_produced;
    logic [COUNT_BITS-1:0] cur_limit;
    logic [COUNT_BITS-1:0] room;
    logic [COUNT_BITS-1:0] run_n;
    logic [REP_W-1:0]      lit_left;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    generate
        if (COUNT_BITS >= SIZE_W) begin : g_wide
            assign size_sat = COUNT_BITS'(i_out_size);
        end else begin : g_narrow
            assign size_sat = (|i_out_size[SIZE_W-1:COUNT_BITS]) ? '1
                                                                 : i_out_size[COUNT_BITS-1:0];
        end
    endgenerate

    always_comb begin
        cur_phase    = r_frame_start ? PH_HEADER : r_phase;
        cur_pending  = r_frame_start ? '0 : r_pending;
        cur_produced = r_frame_start ? '0 : r_produced;
        cur_limit    = r_frame_start ? size_sat : r_limit;

        room     = cur_limit - cur_produced;
        run_n    = (COUNT_BITS'(cur_pending) > room) ? room : COUNT_BITS'(cur_pending);
        lit_left = (cur_pending != '0) ? cur_pending - REP_W'(1) : cur_pending;

        n_phase      = cur_phase;
        n_pending    = cur_pending;
        n_produced   = cur_produced;
        n_limit      = cur_limit;
        n_out_value  = '0;
        n_repeat_res = '0;

        if (cur_produced < cur_limit) begin
            case (cur_phase)
                PH_LITERAL: begin
                    n_out_value  = i_in_byte;
                    n_repeat_res = REP_W'(1);
                    n_produced   = cur_produced + COUNT_BITS'(1);
                    n_pending    = lit_left;
                    n_phase      = (lit_left == '0) ? PH_HEADER : PH_LITERAL;
                end
                PH_RUNVAL: begin
                    n_repeat_res = run_n[REP_W-1:0];
                    n_out_value  = (run_n != '0) ? i_in_byte : '0;
                    n_produced   = cur_produced + run_n;
                    n_pending    = '0;
                    n_phase      = PH_HEADER;
                end
                default: begin
                    if (i_in_byte[LIT_FLAG_BIT]) begin
                        n_pending = i_in_byte[REP_W-1:0] & LEN_MASK;
                        n_phase   = ((i_in_byte[REP_W-1:0] & LEN_MASK) != '0)
                                    ? PH_LITERAL : PH_HEADER;
                    end else begin
                        n_pending = i_in_byte[REP_W-1:0];
                        n_phase   = PH_RUNVAL;
                    end
                end
            endcase
        end

        n_output_full = (n_produced >= cur_limit);
        n_frame_start = i_in_last;

        if (i_in_last) begin
            n_phase   = PH_HEADER;
            n_pending = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_pending     <= '0;
            r_produced    <= '0;
            r_limit       <= '0;
            r_frame_start <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_phase       <= n_phase;
                r_pending     <= n_pending;
                r_produced    <= n_produced;
                r_limit       <= n_limit;
                r_frame_start <= n_frame_start;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_value   <= n_out_value;
            r_repeat_res  <= n_repeat_res;
            r_frame_end   <= i_in_last;
            r_output_full <= n_output_full;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_value   = r_out_value;
    assign o_repeat_res  = r_repeat_res;
    assign o_frame_end   = r_frame_end;
    assign o_output_full = r_output_full;

    // empty beats carry a zero value
    a_zero_rep_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_repeat_res == '0) |-> (o_out_value == '0))
        else $error("nonzero value with zero repeat");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_last_reopens_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in_last |=> r_frame_start)
        else $error("frame not reopened after last beat");

    a_produced_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_frame_start |-> (r_produced <= r_limit))
        else $error("produced count beyond limit");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while output stalled");

endmodule

@@ tb/sv/tb_rle_byte_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rle_byte_decoder
// Self-checking bench for the run-length byte decoder.
// ----------------------------------------------------------------------------
// A directed table covers the zero and full limits, empty literal headers,
// zero runs, clipped runs and truncated frames. Random frames of well-formed
// literal and run chunks follow, with some noise and broken endings mixed in.
// Each accepted beat is predicted in the bench and compared, field by field,
// with the beat that leaves the block. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_rle_byte_decoder
    import rbd_pkg::*;
;

    localparam int N_ITEMS    = 800;
    localparam int IDLE_LIMIT = 1000;

    typedef enum logic [1:0] {
        PH_HDR  = 2'd0,
        PH_LIT  = 2'd1,
        PH_RUNV = 2'd2
    } t_dec_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic [REP_W-1:0]  rep;
        logic              frame_end;
        logic              full;
    } t_beat_res;

    typedef struct {
        logic [BYTE_W-1:0] b;
        logic [SIZE_W-1:0] size;
        logic              last;
        bit                typed;
        t_beat_res         res;
    } t_stim;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [BYTE_W-1:0] i_in_byte;
    logic [SIZE_W-1:0] i_out_size;
    logic              i_in_last;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [BYTE_W-1:0] o_out_value;
    logic [REP_W-1:0]  o_repeat_res;
    logic              o_frame_end;
    logic              o_output_full;

    rle_byte_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .i_out_size    (i_out_size),
        .i_in_last     (i_in_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_value   (o_out_value),
        .o_repeat_res  (o_repeat_res),
        .o_frame_end   (o_frame_end),
        .o_output_full (o_output_full)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // predictor state
    t_dec_phase        dec_phase;
    logic [6:0]        run_left;
    logic [SIZE_W-1:0] bytes_made;
    logic [SIZE_W-1:0] byte_limit;
    bit                frame_open;

    t_beat_res expected_beats[$];
    t_stim     dir_tab[$];
    t_stim     frame_beats[$];
    int        errors;
    int        items_sent;
    int        idle_cyc;
    bit        calm;

    function automatic t_beat_res decode_byte(logic [BYTE_W-1:0] b, logic [SIZE_W-1:0] size,
                                              logic last);
        t_beat_res         r;
        logic [SIZE_W-1:0] room;
        logic [SIZE_W-1:0] n;
        r = '0;
        if (frame_open) begin
            byte_limit = size;
            bytes_made = '0;
            dec_phase  = PH_HDR;
            run_left   = '0;
            frame_open = 1'b0;
        end
        if (bytes_made < byte_limit) begin
            case (dec_phase)
                PH_LIT: begin
                    r.value = b;
                    r.rep   = 7'd1;
                    bytes_made++;
                    if (run_left > 0) run_left--;
                    if (run_left == 0) dec_phase = PH_HDR;
                end
                PH_RUNV: begin
                    room = byte_limit - bytes_made;
                    n    = SIZE_W'(run_left);
                    if (n > room) n = room;
                    r.rep      = n[REP_W-1:0];
                    r.value    = (r.rep != 0) ? b : '0;
                    bytes_made = bytes_made + n;
                    run_left   = '0;
                    dec_phase  = PH_HDR;
                end
                default: begin
                    if (b[LIT_FLAG_BIT]) begin
                        run_left  = b[6:0] & LEN_MASK;
                        dec_phase = (run_left != 0) ? PH_LIT : PH_HDR;
                    end else begin
                        run_left  = b[6:0];
                        dec_phase = PH_RUNV;
                    end
                end
            endcase
        end
        r.frame_end = last;
        r.full      = (bytes_made >= byte_limit);
        if (last) begin
            frame_open = 1'b1;
            dec_phase  = PH_HDR;
            run_left   = '0;
        end
        return r;
    endfunction

    task automatic add_row(logic [7:0] b, logic [23:0] size, logic last, bit typed,
                           logic [7:0] val = 0, logic [6:0] rep = 0, logic fe = 0,
                           logic full = 0);
        t_stim s;
        s.b     = b;
        s.size  = size;
        s.last  = last;
        s.typed = typed;
        s.res   = '{val, rep, fe, full};
        dir_tab.push_back(s);
    endtask

    task automatic push_beat(logic [7:0] b, logic [23:0] size);
        t_stim s;
        s.b     = b;
        s.size  = size;
        s.last  = 1'b0;
        s.typed = 1'b0;
        s.res   = '0;
        frame_beats.push_back(s);
    endtask

    // random frame: mostly well-formed chunks, sometimes noise or a cut end
    task automatic build_frame();
        int          n_chunks;
        int          kind;
        int          n;
        int          k;
        logic [23:0] lim;
        bit          cut;
        frame_beats.delete();
        case ($urandom_range(0, 19))
            0:       lim = 24'd0;
            1:       lim = 24'hFFFFFF;
            2:       lim = 24'($urandom);
            default: lim = 24'($urandom_range(1, 400));
        endcase
        n_chunks = $urandom_range(1, 8);
        cut      = 1'b0;
        for (int c = 0; c < n_chunks && !cut; c++) begin
            kind = $urandom_range(0, 9);
            if (kind <= 3) begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 8);
                push_beat(8'h80 | 8'(n), 24'($urandom));
                for (int i = 0; i < n; i++) push_beat(8'($urandom), 24'($urandom));
            end else if (kind <= 7) begin
                push_beat(8'($urandom_range(0, 127)), 24'($urandom));
                push_beat(8'($urandom), 24'($urandom));
            end else if (kind == 8) begin
                push_beat(8'($urandom), 24'($urandom));
            end else begin
                cut = 1'b1;
                if ($urandom_range(0, 1) == 1) begin
                    n = $urandom_range(2, 20);
                    k = $urandom_range(0, n - 1);
                    push_beat(8'h80 | 8'(n), 24'($urandom));
                    for (int i = 0; i < k; i++) push_beat(8'($urandom), 24'($urandom));
                end else begin
                    push_beat(8'($urandom_range(0, 127)), 24'($urandom));
                end
            end
        end
        frame_beats[0].size                   = lim;
        frame_beats[frame_beats.size()-1].last = 1'b1;
    endtask

    task automatic send_beat(t_stim s);
        int        gap;
        t_beat_res r;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= s.b;
        i_out_size <= s.size;
        i_in_last  <= s.last;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        r = decode_byte(s.b, s.size, s.last);
        expected_beats.push_back(s.typed ? s.res : r);
        items_sent++;
    endtask

    task automatic drain_wait();
        i_in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_beat();
        t_beat_res e;
        if (expected_beats.size() == 0) begin
            $display("%0t: unexpected beat value=%h rep=%0d end=%b full=%b", $time,
                     o_out_value, o_repeat_res, o_frame_end, o_output_full);
            errors++;
        end else begin
            e = expected_beats.pop_front();
            if (o_out_value !== e.value) begin
                $display("%0t: out_value exp %h got %h", $time, e.value, o_out_value);
                errors++;
            end
            if (o_repeat_res !== e.rep) begin
                $display("%0t: repeat_res exp %0d got %0d", $time, e.rep, o_repeat_res);
                errors++;
            end
            if (o_frame_end !== e.frame_end) begin
                $display("%0t: frame_end exp %b got %b", $time, e.frame_end, o_frame_end);
                errors++;
            end
            if (o_output_full !== e.full) begin
                $display("%0t: output_full exp %b got %b", $time, e.full, o_output_full);
                errors++;
            end
        end
    endtask

    // receiver
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(negedge i_clk); while (!o_out_valid);
            check_beat();
            @(posedge i_clk);
        end
    end

    // watchdog on stalled handshakes
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cyc = 0;
            end else begin
                idle_cyc++;
            end
            if (idle_cyc >= IDLE_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("tb_rle_byte_decoder NOT OK");
                $finish;
            end
        end
    end

    // sender and run control
    initial begin
        bit paused;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_byte   = '0;
        i_out_size  = '0;
        i_in_last   = 1'b0;
        i_out_ready = 1'b0;
        errors      = 0;
        items_sent  = 0;
        idle_cyc    = 0;
        calm        = 1'b0;
        paused      = 1'b0;
        dec_phase   = PH_HDR;
        run_left    = '0;
        bytes_made  = '0;
        byte_limit  = '0;
        frame_open  = 1'b1;

        // zero limit right after reset
        add_row(8'h05, 24'h000000, 1'b0, 1, 8'h00, 7'd0, 1'b0, 1'b1);
        add_row(8'hFF, 24'hFFFFFF, 1'b1, 1, 8'h00, 7'd0, 1'b1, 1'b1);
        // full limit: empty literal header, zero run, longest run, literals
        add_row(8'h80, 24'hFFFFFF, 1'b0, 1, 8'h00, 7'd0, 1'b0, 1'b0);
        add_row(8'h00, 24'h000000, 1'b0, 1, 8'h00, 7'd0, 1'b0, 1'b0);
        add_row(8'hAB, 24'h000000, 1'b0, 1, 8'h00, 7'd0, 1'b0, 1'b0);
        add_row(8'h7F, 24'h123456, 1'b0, 1, 8'h00, 7'd0, 1'b0, 1'b0);
        add_row(8'hFF, 24'h000000, 1'b0, 1, 8'hFF, 7'd127, 1'b0, 1'b0);
        add_row(8'h82, 24'h000000, 1'b0, 1, 8'h00, 7'd0, 1'b0, 1'b0);
        add_row(8'h00, 24'h000000, 1'b0, 1, 8'h00, 7'd1, 1'b0, 1'b0);
        add_row(8'hFF, 24'hFFFFFF, 1'b0, 1, 8'hFF, 7'd1, 1'b0, 1'b0);
        add_row(8'hFF, 24'h000000, 1'b0, 1, 8'h00, 7'd0, 1'b0, 1'b0);
        add_row(8'h3C, 24'h000000, 1'b1, 1, 8'h3C, 7'd1, 1'b1, 1'b0);
        // clipped run, then the rest of the frame is ignored
        add_row(8'h7F, 24'd5, 1'b0, 1, 8'h00, 7'd0, 1'b0, 1'b0);
        add_row(8'h55, 24'd0, 1'b0, 1, 8'h55, 7'd5, 1'b0, 1'b1);
        add_row(8'h81, 24'd0, 1'b0, 1, 8'h00, 7'd0, 1'b0, 1'b1);
        add_row(8'h12, 24'd0, 1'b1, 1, 8'h00, 7'd0, 1'b1, 1'b1);
        // frame cut before its run value; next frame starts clean
        add_row(8'h02, 24'd3, 1'b1, 0);
        add_row(8'h00, 24'd3, 1'b1, 1, 8'h00, 7'd0, 1'b1, 1'b0);
        add_row(8'h83, 24'd1, 1'b0, 1, 8'h00, 7'd0, 1'b0, 1'b0);
        add_row(8'h9A, 24'd0, 1'b0, 1, 8'h9A, 7'd1, 1'b0, 1'b1);
        add_row(8'h44, 24'd0, 1'b1, 1, 8'h00, 7'd0, 1'b1, 1'b1);
        add_row(8'h05, 24'd1000, 1'b0, 0);
        add_row(8'h77, 24'd0, 1'b0, 0);
        add_row(8'h81, 24'd0, 1'b0, 0);
        add_row(8'h10, 24'd0, 1'b1, 0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) send_beat(dir_tab[i]);
        drain_wait();

        while (items_sent < N_ITEMS) begin
            if ($urandom_range(0, 3) == 0) calm = ~calm;
            build_frame();
            foreach (frame_beats[i]) send_beat(frame_beats[i]);
            if (!paused && items_sent >= N_ITEMS / 2) begin
                paused = 1'b1;
                drain_wait();
            end
        end
        drain_wait();
        repeat (20) @(posedge i_clk);

        if (errors == 0) begin
            $display("tb_rle_byte_decoder OK");
        end else begin
            $display("tb_rle_byte_decoder NOT OK");
        end
        $finish;
    end

endmodule
